// ----- hw/rtl/bps_pkg.sv -----
// Shared types, codes and defaults for the beacon payload scheduler.
`timescale 1ns / 1ps
package bps_pkg;

  localparam int NumClientsDef      = 8;
  localparam int QueueDepthDef      = 16;
  localparam int BeaconHdrBytesDef  = 16;
  localparam int PayloadHdrBytesDef = 4;

  localparam logic [15:0] MaxPacketReset = 16'd1024;

  localparam logic [2:0] OpRegister   = 3'd0;
  localparam logic [2:0] OpDeregister = 3'd1;
  localparam logic [2:0] OpEnqueue    = 3'd2;
  localparam logic [2:0] OpClear      = 3'd3;
  localparam logic [2:0] OpQuery      = 3'd4;
  localparam logic [2:0] OpGenerate   = 3'd5;

  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StAlreadyReg  = 3'd1;
  localparam logic [2:0] StBadPayload  = 3'd2;
  localparam logic [2:0] StBadQueue    = 3'd3;
  localparam logic [2:0] StUnknown     = 3'd4;
  localparam logic [2:0] StTooLarge    = 3'd5;
  localparam logic [2:0] StEmpty       = 3'd6;

  localparam logic [1:0] ModeOnce     = 2'd0;
  localparam logic [1:0] ModeDropHead = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic gen_rd;
    logic gen_commit;
    logic gen_fin;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_gen;
    logic in_bad;
    logic out_free;
    logic ev_ok;
    logic last_client;
  } sts_t;

endpackage

// ----- hw/rtl/bps_ctrl.sv -----
// Controller state machine of the beacon payload scheduler.
`timescale 1ns / 1ps
module bps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bps_pkg::sts_t sts_i,
  output bps_pkg::cmd_t cmd_o
);
  import bps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_GEN_RD = 5'b00100,
    S_GEN_EV = 5'b01000,
    S_GEN_FN = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_bad) state_d = S_IDLE;
          else if (sts_i.in_gen) state_d = S_GEN_RD;
          else state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_GEN_RD: begin
        cmd_o.gen_rd = 1'b1;
        state_d      = S_GEN_EV;
      end
      S_GEN_EV: begin
        if (sts_i.ev_ok) begin
          cmd_o.gen_commit = 1'b1;
          state_d = sts_i.last_client ? S_GEN_FN : S_GEN_RD;
        end
      end
      S_GEN_FN: begin
        if (sts_i.out_free) begin
          cmd_o.gen_fin = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // a result stage only runs when the output register can take it
  a_exec_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> sts_i.out_free) else $error("exec without free output");
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gen_fin |-> sts_i.out_free) else $error("finish without free output");
  a_rd_then_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gen_rd |=> (state_q == S_GEN_EV)) else $error("walk read not followed by eval");

endmodule

// ----- hw/rtl/bps_dp.sv -----
// Datapath of the beacon payload scheduler: client tables, queue memory, output register.
`timescale 1ns / 1ps
module bps_dp #(
  parameter int NUM_CLIENTS       = bps_pkg::NumClientsDef,
  parameter int QUEUE_DEPTH       = bps_pkg::QueueDepthDef,
  parameter int BEACON_HDR_BYTES  = bps_pkg::BeaconHdrBytesDef,
  parameter int PAYLOAD_HDR_BYTES = bps_pkg::PayloadHdrBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic [63:0]   in_data_i,
  input  logic [2:0]    in_op_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [63:0]   out_data_o,
  output logic          out_has_o,
  output logic          out_last_o,
  input  bps_pkg::cmd_t cmd_i,
  output bps_pkg::sts_t sts_o
);
  import bps_pkg::*;

  localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = NUM_CLIENTS * QUEUE_DEPTH;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;
  localparam logic signed [17:0] BeaconHdr  = 18'(BEACON_HDR_BYTES);
  localparam logic signed [17:0] PayloadLim = 18'(BEACON_HDR_BYTES + PAYLOAD_HDR_BYTES);
  localparam logic [16:0] PayloadHdr = 17'(PAYLOAD_HDR_BYTES);

  logic [15:0] mpb_q;

  // captured transaction
  logic [2:0]  op_q, cid_q;
  logic [1:0]  qm_q;
  logic [15:0] mp_q, len_q, hdl_q;
  logic [4:0]  me_q;

  // per-client tables
  logic [NUM_CLIENTS-1:0] reg_q, full_q;
  logic [1:0]  mode_q   [NUM_CLIENTS];
  logic [15:0] maxpay_q [NUM_CLIENTS];
  logic [4:0]  maxent_q [NUM_CLIENTS];
  logic [31:0] bufent_q [NUM_CLIENTS];
  logic [HW-1:0] head_q [NUM_CLIENTS];
  logic [NW-1:0] cnt_q  [NUM_CLIENTS];
  logic [31:0] mem [MD];
  logic [31:0] mem_rdata_q;

  // beacon walk
  logic [15:0] seq_q;
  logic [CW-1:0] walk_q;
  logic signed [17:0] rem_q;
  logic pend_q;
  logic [CW-1:0] pend_cid_q;
  logic [31:0] pend_ent_q;

  logic out_valid_q, out_has_q, out_last_q;
  logic [63:0] out_data_q;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------- single operations ----------------
  logic [CW-1:0] cidx;
  logic unknown;
  logic signed [17:0] plimit;
  logic [2:0] st;
  logic [4:0] qcnt;
  logic upd_reg, upd_dereg, upd_buf, upd_clr, upd_q;
  logic [HW-1:0] new_head;
  logic [NW-1:0] new_cnt;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic qfull;
  logic [HW-1:0] hsel;
  logic [NW-1:0] csel;
  int pos;

  assign cidx   = CW'(cid_q);
  assign unknown = (int'(cid_q) >= NUM_CLIENTS);
  assign plimit = $signed({2'b00, mpb_q}) - PayloadLim;

  always_comb begin
    st = StOk; qcnt = '0;
    upd_reg = 1'b0; upd_dereg = 1'b0; upd_buf = 1'b0; upd_clr = 1'b0; upd_q = 1'b0;
    hsel = head_q[cidx]; csel = cnt_q[cidx];
    new_head = hsel; new_cnt = csel;
    mem_we = 1'b0; mem_waddr = '0; qfull = 1'b0; pos = 0;
    if (unknown) begin
      st = StUnknown;
    end else if (op_q == OpRegister) begin
      if (reg_q[cidx]) st = StAlreadyReg;
      else if (mp_q == 16'd0 || $signed({2'b00, mp_q}) > plimit) st = StBadPayload;
      else if (qm_q[1] && (me_q == 5'd0 || int'(me_q) > QUEUE_DEPTH)) st = StBadQueue;
      else upd_reg = 1'b1;
    end else if (!reg_q[cidx]) begin
      st = StUnknown;
    end else begin
      case (op_q)
        OpDeregister: upd_dereg = 1'b1;
        OpEnqueue: begin
          if (len_q > maxpay_q[cidx] || $signed({2'b00, len_q}) > plimit) st = StTooLarge;
          else if (len_q == 16'd0) st = StEmpty;
          else if (!mode_q[cidx][1]) upd_buf = 1'b1;
          else begin
            upd_q = 1'b1;
            qfull = (int'(csel) >= int'(maxent_q[cidx]));
            if (qfull && mode_q[cidx] == ModeDropHead && csel != '0) begin
              new_head = (int'(hsel) == QUEUE_DEPTH - 1) ? '0 : hsel + 1'b1;
              new_cnt  = csel - 1'b1;
              qfull    = 1'b0;
            end
            if (!qfull && int'(new_cnt) < QUEUE_DEPTH) begin
              pos = int'(new_head) + int'(new_cnt);
              if (pos >= QUEUE_DEPTH) pos = pos - QUEUE_DEPTH;
              mem_we    = cmd_i.exec;
              mem_waddr = AW'(int'(cidx) * QUEUE_DEPTH + pos);
              new_cnt   = new_cnt + 1'b1;
            end
          end
        end
        OpClear: upd_clr = 1'b1;
        OpQuery: qcnt = mode_q[cidx][1] ? 5'(csel) : {4'd0, full_q[cidx]};
        default: st = StOk;
      endcase
    end
  end

  // ---------------- beacon walk ----------------
  logic w_reg, q_take, b_take, got, ev_ok;
  logic [31:0] ent;
  logic [16:0] need_q, need_b, need;
  logic [AW-1:0] mem_raddr;

  assign mem_raddr = AW'(int'(walk_q) * QUEUE_DEPTH + int'(head_q[walk_q]));
  assign w_reg  = reg_q[walk_q];
  assign need_q = {1'b0, mem_rdata_q[31:16]} + PayloadHdr;
  assign need_b = {1'b0, bufent_q[walk_q][31:16]} + PayloadHdr;
  assign q_take = w_reg && mode_q[walk_q][1] && cnt_q[walk_q] != '0
                  && $signed({1'b0, need_q}) <= rem_q;
  assign b_take = !q_take && w_reg && full_q[walk_q]
                  && $signed({1'b0, need_b}) <= rem_q;
  assign got    = q_take || b_take;
  assign ent    = q_take ? mem_rdata_q : bufent_q[walk_q];
  assign need   = q_take ? need_q : need_b;
  assign ev_ok  = !(got && pend_q && !out_free);

  assign sts_o.in_gen      = (in_op_i == OpGenerate);
  assign sts_o.in_bad      = (in_op_i > OpGenerate);
  assign sts_o.out_free    = out_free;
  assign sts_o.ev_ok       = ev_ok;
  assign sts_o.last_client = (walk_q == CW'(NUM_CLIENTS - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= {len_q, hdl_q};
    if (cmd_i.gen_rd) mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_op_i;
      cid_q <= in_data_i[2:0];
      qm_q  <= in_data_i[4:3];
      mp_q  <= in_data_i[20:5];
      me_q  <= in_data_i[25:21];
      len_q <= in_data_i[41:26];
      hdl_q <= in_data_i[57:42];
    end
    if (cmd_i.exec && upd_reg) begin
      mode_q[cidx]   <= qm_q;
      maxpay_q[cidx] <= mp_q;
      maxent_q[cidx] <= me_q;
    end
    if (cmd_i.exec && upd_buf) bufent_q[cidx] <= {len_q, hdl_q};
    if (cmd_i.gen_commit && got) begin
      pend_cid_q <= walk_q;
      pend_ent_q <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpb_q  <= MaxPacketReset;
      reg_q  <= '0;
      full_q <= '0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      seq_q  <= '0;
      walk_q <= '0;
      rem_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) mpb_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        walk_q <= '0;
        rem_q  <= $signed({2'b00, mpb_q}) - BeaconHdr;
        pend_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        if (upd_reg) begin
          reg_q[cidx]  <= 1'b1;
          full_q[cidx] <= 1'b0;
          head_q[cidx] <= '0;
          cnt_q[cidx]  <= '0;
        end
        if (upd_dereg) reg_q[cidx] <= 1'b0;
        if (upd_buf) full_q[cidx] <= 1'b1;
        if (upd_clr) begin
          full_q[cidx] <= 1'b0;
          head_q[cidx] <= '0;
          cnt_q[cidx]  <= '0;
        end
        if (upd_q) begin
          head_q[cidx] <= new_head;
          cnt_q[cidx]  <= new_cnt;
        end
      end
      if (cmd_i.gen_commit) begin
        walk_q <= walk_q + 1'b1;
        if (got) begin
          rem_q  <= rem_q - $signed({1'b0, need});
          pend_q <= 1'b1;
        end
        if (q_take) begin
          head_q[walk_q] <= (int'(head_q[walk_q]) == QUEUE_DEPTH - 1) ? '0
                            : head_q[walk_q] + 1'b1;
          cnt_q[walk_q]  <= cnt_q[walk_q] - 1'b1;
        end
        if (b_take && mode_q[walk_q] == ModeOnce) full_q[walk_q] <= 1'b0;
      end
      if (cmd_i.gen_fin && pend_q) seq_q <= seq_q + 1'b1;
    end
  end

  // output register: st[2:0] cnt[7:3] cid[10:8] len[26:11] hdl[42:27] seq[58:43]
  logic push_pend;
  assign push_pend = (cmd_i.gen_commit && got && pend_q) || (cmd_i.gen_fin && pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.exec || cmd_i.gen_fin || push_pend) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_data_q <= {5'd0, 16'd0, 16'd0, 16'd0, 3'd0, qcnt, st};
      out_has_q  <= 1'b0;
      out_last_q <= 1'b1;
    end else if (push_pend) begin
      out_data_q <= {5'd0, seq_q, pend_ent_q[15:0], pend_ent_q[31:16],
                     3'(pend_cid_q), 5'd0, StOk};
      out_has_q  <= 1'b1;
      out_last_q <= cmd_i.gen_fin;
    end else if (cmd_i.gen_fin) begin
      out_data_q <= {5'd0, seq_q, 16'd0, 16'd0, 3'd0, 5'd0, StOk};
      out_has_q  <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_has_o   = out_has_q;
  assign out_last_o  = out_last_q;

  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gen_commit |-> ev_ok) else $error("walk step taken while output blocked");
  a_rem_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.gen_commit && got) |=> (rem_q >= 0)) else $error("packet budget overdrawn");
  a_take_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_take && b_take)) else $error("queue and buffer taken together");

endmodule

// ----- hw/rtl/beacon_payload_scheduler.sv -----
// Top level of the beacon payload scheduler.
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser opcode, tdata operands
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tuser has_payload, tdata result, tlast
//  cfg       | in  | cfg_we_i                     | cfg_wdata_i max_packet_bytes
// A single op is accepted and then executed; its result is loaded when the output register
// is free. Generate walks over the client slots (one queue memory read and one evaluation
// per slot) and then finishes; its final result is loaded when the output register is
// free. One transaction is worked at a time; the next is accepted once the current result
// is loaded into the output register. Reset is asynchronous and active low; the queue
// memory is not cleared. A stalled output holds the walk.
`timescale 1ns / 1ps
module beacon_payload_scheduler #(
  parameter int NUM_CLIENTS       = bps_pkg::NumClientsDef,
  parameter int QUEUE_DEPTH       = bps_pkg::QueueDepthDef,
  parameter int BEACON_HDR_BYTES  = bps_pkg::BeaconHdrBytesDef,
  parameter int PAYLOAD_HDR_BYTES = bps_pkg::PayloadHdrBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // client_id, queue_mode, max_payload_bytes, max_entries, payload_length, payload_handle
  input  logic [63:0] s_axis_tdata,
  // opcode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, buffered_count, out_client_id, out_length, out_handle, beacon_seq
  output logic [63:0] m_axis_tdata,
  // has_payload
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import bps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bps_dp #(
    .NUM_CLIENTS       (NUM_CLIENTS),
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .BEACON_HDR_BYTES  (BEACON_HDR_BYTES),
    .PAYLOAD_HDR_BYTES (PAYLOAD_HDR_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_has_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- tb/sv/tb_beacon_payload_scheduler.sv -----
// Self-checking testbench for the beacon payload scheduler: directed and random stream traffic.
`timescale 1ns / 1ps
module tb_beacon_payload_scheduler;
  import bps_pkg::*;

  localparam int NCli = NumClientsDef;
  localparam int QDep = QueueDepthDef;
  localparam int BHdr = BeaconHdrBytesDef;
  localparam int PHdr = PayloadHdrBytesDef;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  count;
    logic        has_payload;
    logic [2:0]  client;
    logic [15:0] length;
    logic [15:0] handle;
    logic [15:0] seq;
    logic        last;
  } beacon_res_t;

  class beacon_scoreboard;
    logic [15:0] max_packet;
    bit          registered [NCli];
    logic [1:0]  mode [NCli];
    logic [15:0] max_payload [NCli];
    logic [4:0]  max_entries [NCli];
    bit          buf_full [NCli];
    logic [31:0] buf_entry [NCli];
    logic [31:0] store [NCli][QDep];
    int          head [NCli];
    int          count [NCli];
    logic [15:0] counter;
    beacon_res_t pending[$];
    int          mismatches;
    int          checked;

    function new();
      max_packet = MaxPacketReset;
      counter = '0;
      mismatches = 0;
      checked = 0;
      for (int i = 0; i < NCli; i++) begin
        registered[i] = 0; buf_full[i] = 0; head[i] = 0; count[i] = 0;
      end
    endfunction

    function void add_expected(beacon_res_t r);
      pending = {pending, r};
    endfunction

    function void push_single(logic [2:0] st, logic [4:0] cnt);
      beacon_res_t r;
      r = '0;
      r.status = st; r.count = cnt; r.last = 1'b1;
      add_expected(r);
    endfunction

    // Note an accepted request and queue up the results it should cause.
    function void note_request(logic [2:0] op, logic [2:0] c, logic [1:0] qm,
                               logic [15:0] mp, logic [4:0] me, logic [15:0] len,
                               logic [15:0] hdl);
      int limit;
      int remaining;
      int n;
      bit got;
      bit full;
      logic [31:0] e;
      beacon_res_t r;
      limit = int'(max_packet) - (BHdr + PHdr);
      if (op > OpGenerate) return;
      if (op == OpGenerate) begin
        remaining = int'(max_packet) - BHdr;
        n = 0;
        for (int i = 0; i < NCli; i++) begin
          got = 0; e = '0;
          if (!registered[i]) continue;
          if (mode[i] >= 2 && count[i] > 0) begin
            if (int'(store[i][head[i]][31:16]) + PHdr <= remaining) begin
              e = store[i][head[i]]; got = 1;
              head[i] = (head[i] + 1) % QDep; count[i]--;
            end
          end
          if (!got && buf_full[i] && int'(buf_entry[i][31:16]) + PHdr <= remaining) begin
            e = buf_entry[i]; got = 1;
            if (mode[i] == ModeOnce) buf_full[i] = 0;
          end
          if (got) begin
            remaining -= int'(e[31:16]) + PHdr;
            r = '0;
            r.has_payload = 1'b1; r.client = i[2:0];
            r.length = e[31:16]; r.handle = e[15:0]; r.seq = counter;
            add_expected(r);
            n++;
          end
        end
        if (n == 0) begin
          r = '0; r.seq = counter; r.last = 1'b1;
          add_expected(r);
        end else begin
          pending[$].last = 1'b1;
          counter = counter + 16'd1;
        end
        return;
      end
      if (op == OpRegister) begin
        if (registered[c]) push_single(StAlreadyReg, '0);
        else if (mp == 0 || int'(mp) > limit) push_single(StBadPayload, '0);
        else if (qm >= 2 && (me == 0 || me > QDep)) push_single(StBadQueue, '0);
        else begin
          registered[c] = 1; mode[c] = qm; max_payload[c] = mp; max_entries[c] = me;
          buf_full[c] = 0; head[c] = 0; count[c] = 0;
          push_single(StOk, '0);
        end
      end else if (!registered[c]) push_single(StUnknown, '0);
      else if (op == OpDeregister) begin
        registered[c] = 0; push_single(StOk, '0);
      end else if (op == OpEnqueue) begin
        if (len > max_payload[c] || int'(len) > limit) push_single(StTooLarge, '0);
        else if (len == 0) push_single(StEmpty, '0);
        else begin
          if (mode[c] < 2) begin
            buf_full[c] = 1; buf_entry[c] = {len, hdl};
          end else begin
            full = count[c] >= int'(max_entries[c]);
            if (full && mode[c] == ModeDropHead && count[c] > 0) begin
              head[c] = (head[c] + 1) % QDep; count[c]--; full = 0;
            end
            if (!full && count[c] < QDep) begin
              store[c][(head[c] + count[c]) % QDep] = {len, hdl};
              count[c]++;
            end
          end
          push_single(StOk, '0);
        end
      end else if (op == OpClear) begin
        buf_full[c] = 0; count[c] = 0; head[c] = 0;
        push_single(StOk, '0);
      end else begin
        push_single(StOk, (mode[c] < 2) ? {4'd0, buf_full[c]} : count[c][4:0]);
      end
    endfunction

    function void check_result(beacon_res_t got);
      beacon_res_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch #%0d: expected st=%0d cnt=%0d hp=%0d cid=%0d len=%0d hdl=%0d",
                 mismatches, want.status, want.count, want.has_payload, want.client,
                 want.length, want.handle);
          $write(" seq=%0d last=%0d, got st=%0d cnt=%0d hp=%0d cid=%0d len=%0d hdl=%0d",
                 want.seq, want.last, got.status, got.count, got.has_payload,
                 got.client, got.length, got.handle);
          $display(" seq=%0d last=%0d", got.seq, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  beacon_payload_scheduler uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  beacon_scoreboard sb;
  int  send_idle_pct;
  int  stall_pct;
  int  cycles;
  int  sent;
  bit  timed_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit && !timed_out) begin
      timed_out = 1;
      $display("timeout after %0d cycles", cycles);
      $display("beacon_payload_scheduler test failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, check every accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tuser,
                         m_axis_tdata[10:8], m_axis_tdata[26:11], m_axis_tdata[42:27],
                         m_axis_tdata[58:43], m_axis_tlast});
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Valid is left high after a transaction; the next idle cycle or the caller drops it.
  task automatic send_item(logic [2:0] op, logic [2:0] c, logic [1:0] qm, logic [15:0] mp,
                           logic [4:0] me, logic [15:0] len, logic [15:0] hdl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, hdl, len, me, mp, qm, c};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, c, qm, mp, me, len, hdl);
    sent++;
  endtask

  // Drain and let the block settle before touching the register.
  task automatic write_max_packet(logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * NCli + 8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.max_packet = v;
  endtask

  task automatic random_item();
    int k;
    logic [2:0] c;
    logic [1:0] qm;
    logic [15:0] mp;
    logic [4:0] me;
    logic [15:0] len;
    logic [15:0] hdl;
    k = $urandom_range(99);
    c = 3'($urandom_range(NCli - 1));
    qm = 2'($urandom);
    if ($urandom_range(3) == 0) mp = 16'($urandom);
    else mp = 16'($urandom_range(1, 200));
    me = 5'($urandom_range(0, 17));
    hdl = 16'($urandom);
    if ($urandom_range(9) == 0) len = 16'($urandom);
    else len = 16'($urandom_range(1, 120));
    if (k < 10) send_item(OpRegister, c, qm, mp, me, len, hdl);
    else if (k < 14) send_item(OpDeregister, c, qm, mp, me, len, hdl);
    else if (k < 60) send_item(OpEnqueue, c, qm, mp, me, len, hdl);
    else if (k < 64) send_item(OpClear, c, qm, mp, me, len, hdl);
    else if (k < 72) send_item(OpQuery, c, qm, mp, me, len, hdl);
    else if (k < 97) send_item(OpGenerate, c, qm, mp, me, len, hdl);
    else send_item(3'($urandom_range(6, 7)), c, qm, mp, me, len, hdl);
  endtask

  initial begin
    sb = new();
    cycles = 0; sent = 0; timed_out = 0;
    send_idle_pct = 0; stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty beacon, unknown client, register checks, queue overflow.
    send_item(OpGenerate, 0, 0, 0, 0, 0, 0);
    send_item(OpEnqueue, 7, 0, 0, 0, 10, 1);
    send_item(OpRegister, 0, ModeOnce, 0, 0, 0, 0);
    send_item(OpRegister, 0, ModeOnce, 16'd1005, 0, 0, 0);
    send_item(OpRegister, 0, ModeOnce, 16'd1004, 0, 0, 0);
    send_item(OpRegister, 0, ModeOnce, 16'd100, 0, 0, 0);
    send_item(OpRegister, 1, 2'd1, 16'd200, 0, 0, 0);
    send_item(OpRegister, 2, 2'd2, 16'd300, 5'd0, 0, 0);
    send_item(OpRegister, 2, 2'd2, 16'd300, 5'd17, 0, 0);
    send_item(OpRegister, 2, 2'd2, 16'd300, 5'd2, 0, 0);
    send_item(OpRegister, 3, ModeDropHead, 16'hffff, 5'd16, 0, 0);
    send_item(OpRegister, 3, ModeDropHead, 16'd1004, 5'd2, 0, 0);
    send_item(OpEnqueue, 0, 0, 0, 0, 16'd101, 16'h1);
    send_item(OpEnqueue, 0, 0, 0, 0, 16'd0, 16'h1);
    send_item(OpEnqueue, 0, 0, 0, 0, 16'd100, 16'hffff);
    send_item(OpEnqueue, 1, 0, 0, 0, 16'd50, 16'h0);
    for (int i = 0; i < 3; i++) send_item(OpEnqueue, 2, 0, 0, 0, 16'(10 + i), 16'(i));
    for (int i = 0; i < 3; i++) send_item(OpEnqueue, 3, 0, 0, 0, 16'(600 + i), 16'(i));
    send_item(OpQuery, 2, 0, 0, 0, 0, 0);
    send_item(OpGenerate, 0, 0, 0, 0, 0, 0);
    send_item(OpGenerate, 0, 0, 0, 0, 0, 0);
    send_item(OpClear, 1, 0, 0, 0, 0, 0);
    send_item(OpDeregister, 3, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_max_packet(16'd1);
        2: write_max_packet(16'hffff);
        3: write_max_packet(16'd20);
        4: write_max_packet(16'd150);
        5: write_max_packet(MaxPacketReset);
        default: ;
      endcase
      for (int j = 0; j < 55; j++) begin
        if (j % 14 == 0) begin
          case ((j / 14 + ph) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
          endcase
        end
        random_item();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * NCli + 8) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results over six packet size settings",
             sent, sb.checked);
    $display("settings included the 1 byte and 65535 byte packet extremes");
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("beacon_payload_scheduler test passed");
    else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending.size());
      $display("beacon_payload_scheduler test failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/bps_pkg.sv
hw/rtl/bps_ctrl.sv
hw/rtl/bps_dp.sv
hw/rtl/beacon_payload_scheduler.sv
tb/sv/tb_beacon_payload_scheduler.sv
